// File: rtl/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/trpa_pkg.sv
package trpa_pkg;

	// Region sizes and page geometry.
	localparam int KERNEL_PAGES_MAX = 1024;
	localparam int USER_PAGES_MAX   = 32768;
	localparam int PAGE_SHIFT       = 12;

	localparam int ADDR_W  = 56;
	localparam int PAGE_W  = ADDR_W - PAGE_SHIFT;
	localparam int K_OFF_W = $clog2(KERNEL_PAGES_MAX);
	localparam int U_OFF_W = $clog2(USER_PAGES_MAX);

	// Register and counter widths.
	localparam int BASE_W  = 44;
	localparam int KCFG_W  = 11;
	localparam int UCFG_W  = 16;
	localparam int K_CNT_W = K_OFF_W + 1;
	localparam int U_CNT_W = U_OFF_W + 1;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 44;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KCOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UCOUNT = 2'd2;

	// Configuration reset values.
	localparam logic [BASE_W-1:0] BASE_RST   = 44'd524288;
	localparam logic [KCFG_W-1:0] KCOUNT_RST = 11'd1024;
	localparam logic [UCFG_W-1:0] UCOUNT_RST = 16'd31744;

	// Request codes.
	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE  = 2'd1;
	localparam logic [1:0] FN_INIT  = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_OOM       = 3'd1;
	localparam logic [2:0] STAT_UNALIGNED = 3'd2;
	localparam logic [2:0] STAT_RANGE     = 3'd3;
	localparam logic [2:0] STAT_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]        func;
		logic              kernel_sel;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		logic [2:0]        status;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic commit;
		logic load_out_eval;
		logic load_out_read;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop;
	} dp_stat_t;

endpackage

// File: rtl/trpa_ram.sv
module trpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/trpa_ctrl.sv
`include "assert_macros.svh"

module trpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  trpa_pkg::dp_stat_t   dp_stat,
	output trpa_pkg::ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       load_out;

	// The result register can take a new item when empty or when being drained.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign load_out = cmd.load_out_eval || cmd.load_out_read;

	// Sequencer: take an item, evaluate it, and wait for the stack read on a pop.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EVAL;
				end
			end
			S_EVAL: begin
				if (dp_stat.pop) begin
					cmd.commit = 1'b1;
					state_d    = S_READ;
				end else if (out_free) begin
					cmd.commit        = 1'b1;
					cmd.load_out_eval = 1'b1;
					state_d           = S_IDLE;
				end
			end
			S_READ: begin
				if (out_free) begin
					cmd.load_out_read = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_IMP(a_load_needs_room, clk, arst_n, load_out, out_free)
	`ASSERT_NXT(a_accept_goes_eval, clk, arst_n, in_valid && in_ready, state_q == S_EVAL)
	`ASSERT_IMP(a_read_after_eval, clk, arst_n, state_q == S_READ, $past(state_q) != S_IDLE)

endmodule

// File: rtl/trpa_dp.sv
`include "assert_macros.svh"

module trpa_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [trpa_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [trpa_pkg::CFG_W-1:0]          cfg_wdata,
	input  trpa_pkg::req_t                      in_item,
	input  trpa_pkg::ctrl_cmd_t                 cmd,
	output trpa_pkg::dp_stat_t                  dp_stat,
	output trpa_pkg::rsp_t                      out_item
);

	// Allocatable pages: stack depth plus the pages above the watermark.
	function automatic logic [trpa_pkg::CNT_W-1:0] free_pages(
		input logic [trpa_pkg::CNT_W-1:0] d,
		input logic [trpa_pkg::CNT_W-1:0] w,
		input logic [trpa_pkg::CNT_W-1:0] c
	);
		logic [trpa_pkg::CNT_W-1:0] rest;
		rest = (c > w) ? c - w : '0;
		return d + rest;
	endfunction

	// Configuration registers.
	logic [trpa_pkg::BASE_W-1:0] cfg_base_q;
	logic [trpa_pkg::KCFG_W-1:0] cfg_kcnt_q;
	logic [trpa_pkg::UCFG_W-1:0] cfg_ucnt_q;

	// Per-region stack depths and watermarks.
	logic [trpa_pkg::K_CNT_W-1:0] k_depth_q;
	logic [trpa_pkg::K_CNT_W-1:0] k_wm_q;
	logic [trpa_pkg::U_CNT_W-1:0] u_depth_q;
	logic [trpa_pkg::U_CNT_W-1:0] u_wm_q;

	// Request held for the duration of one item.
	logic [1:0]                    req_func_q;
	logic                          req_kern_q;
	logic [trpa_pkg::ADDR_W-1:0]   req_addr_q;
	logic [trpa_pkg::PAGE_W:0]     req_start_q;
	trpa_pkg::rsp_t                out_q;

	logic [trpa_pkg::K_CNT_W-1:0]  eff_k;
	logic [trpa_pkg::CNT_W-1:0]    eff_u;
	logic [trpa_pkg::PAGE_W:0]     start_d;

	logic [trpa_pkg::CNT_W-1:0]    sel_depth;
	logic [trpa_pkg::CNT_W-1:0]    sel_wm;
	logic [trpa_pkg::CNT_W-1:0]    sel_cnt;
	logic [trpa_pkg::CNT_W-1:0]    sel_max;

	logic                          can_pop;
	logic                          can_wm;
	logic [trpa_pkg::PAGE_W-1:0]   req_page;
	logic [trpa_pkg::PAGE_W+1:0]   diff;
	logic                          unaligned;
	logic                          range_bad;
	logic                          list_full;
	logic [trpa_pkg::PAGE_W-1:0]   wm_page;
	logic [trpa_pkg::PAGE_W-1:0]   pop_page;
	logic [trpa_pkg::PAGE_W-1:0]   pop_off;

	logic [trpa_pkg::ADDR_W-1:0]   ev_page;
	logic [2:0]                    ev_status;
	logic [trpa_pkg::CNT_W-1:0]    ev_depth;
	logic [trpa_pkg::CNT_W-1:0]    ev_wm;
	logic                          ev_push;
	logic                          ev_pop;
	logic                          ev_reinit;

	logic                          k_we;
	logic                          k_re;
	logic                          u_we;
	logic                          u_re;
	logic [trpa_pkg::K_CNT_W-1:0]  k_top;
	logic [trpa_pkg::U_CNT_W-1:0]  u_top;
	logic [trpa_pkg::K_OFF_W-1:0]  k_rdata;
	logic [trpa_pkg::U_OFF_W-1:0]  u_rdata;

	// Page counts clamp at the region maximum.
	assign eff_k = (cfg_kcnt_q > trpa_pkg::K_CNT_W'(trpa_pkg::KERNEL_PAGES_MAX))
		? trpa_pkg::K_CNT_W'(trpa_pkg::KERNEL_PAGES_MAX) : cfg_kcnt_q;
	assign eff_u = (cfg_ucnt_q > trpa_pkg::CNT_W'(trpa_pkg::USER_PAGES_MAX))
		? trpa_pkg::CNT_W'(trpa_pkg::USER_PAGES_MAX) : cfg_ucnt_q;

	// First page of the selected region, registered with the request. It is one bit
	// wider than a page number, so a user region that starts past the top of the page
	// space rejects every free as out of range.
	assign start_d = in_item.kernel_sel ? {1'b0, cfg_base_q}
		: {1'b0, cfg_base_q} + (trpa_pkg::PAGE_W+1)'(eff_k);

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_base_q <= trpa_pkg::BASE_RST;
			cfg_kcnt_q <= trpa_pkg::KCOUNT_RST;
			cfg_ucnt_q <= trpa_pkg::UCOUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				trpa_pkg::CFG_BASE:   cfg_base_q <= cfg_wdata[trpa_pkg::BASE_W-1:0];
				trpa_pkg::CFG_KCOUNT: cfg_kcnt_q <= cfg_wdata[trpa_pkg::KCFG_W-1:0];
				trpa_pkg::CFG_UCOUNT: cfg_ucnt_q <= cfg_wdata[trpa_pkg::UCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_func_q  <= in_item.func;
			req_kern_q  <= in_item.kernel_sel;
			req_addr_q  <= in_item.free_address;
			req_start_q <= start_d;
		end
	end

	// Operands of the selected region, widened to a common width.
	assign sel_depth = req_kern_q ? trpa_pkg::CNT_W'(k_depth_q) : trpa_pkg::CNT_W'(u_depth_q);
	assign sel_wm    = req_kern_q ? trpa_pkg::CNT_W'(k_wm_q) : trpa_pkg::CNT_W'(u_wm_q);
	assign sel_cnt   = req_kern_q ? trpa_pkg::CNT_W'(eff_k) : eff_u;
	assign sel_max   = req_kern_q ? trpa_pkg::CNT_W'(trpa_pkg::KERNEL_PAGES_MAX)
		: trpa_pkg::CNT_W'(trpa_pkg::USER_PAGES_MAX);

	// Allocation sources and free checks.
	assign can_pop   = (sel_depth != '0) && (sel_depth <= sel_max);
	assign can_wm    = sel_wm < sel_cnt;
	assign req_page  = req_addr_q[trpa_pkg::ADDR_W-1:trpa_pkg::PAGE_SHIFT];
	assign diff      = {2'b00, req_page} - {1'b0, req_start_q};
	assign unaligned = req_addr_q[trpa_pkg::PAGE_SHIFT-1:0] != '0;
	assign range_bad = diff[trpa_pkg::PAGE_W+1]
		|| (diff[trpa_pkg::PAGE_W:0] >= (trpa_pkg::PAGE_W+1)'(sel_cnt));
	assign list_full = (sel_depth >= sel_wm) || (sel_depth >= sel_max);
	assign wm_page   = req_start_q[trpa_pkg::PAGE_W-1:0] + trpa_pkg::PAGE_W'(sel_wm);

	// Outcome of the held request and the region state it leaves.
	always_comb begin
		ev_page   = '0;
		ev_status = trpa_pkg::STAT_OK;
		ev_depth  = sel_depth;
		ev_wm     = sel_wm;
		ev_push   = 1'b0;
		ev_pop    = 1'b0;
		ev_reinit = 1'b0;
		unique case (req_func_q)
			trpa_pkg::FN_ALLOC: begin
				priority if (can_pop) begin
					ev_pop   = 1'b1;
					ev_depth = sel_depth - 1'b1;
				end else if (can_wm) begin
					ev_wm   = sel_wm + 1'b1;
					ev_page = {wm_page, {trpa_pkg::PAGE_SHIFT{1'b0}}};
				end else begin
					ev_status = trpa_pkg::STAT_OOM;
				end
			end
			trpa_pkg::FN_FREE: begin
				priority if (unaligned) begin
					ev_status = trpa_pkg::STAT_UNALIGNED;
				end else if (range_bad) begin
					ev_status = trpa_pkg::STAT_RANGE;
				end else if (list_full) begin
					ev_status = trpa_pkg::STAT_FULL;
				end else begin
					ev_push  = 1'b1;
					ev_depth = sel_depth + 1'b1;
				end
			end
			trpa_pkg::FN_INIT: begin
				ev_reinit = 1'b1;
				ev_depth  = '0;
				ev_wm     = '0;
			end
			default: ;
		endcase
	end

	assign dp_stat.pop = ev_pop;

	// Region state update when the controller commits the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_depth_q <= '0;
			k_wm_q    <= '0;
			u_depth_q <= '0;
			u_wm_q    <= '0;
		end else if (cmd.commit) begin
			if (ev_reinit) begin
				k_depth_q <= '0;
				k_wm_q    <= '0;
				u_depth_q <= '0;
				u_wm_q    <= '0;
			end else if (req_kern_q) begin
				k_depth_q <= ev_depth[trpa_pkg::K_CNT_W-1:0];
				k_wm_q    <= ev_wm[trpa_pkg::K_CNT_W-1:0];
			end else begin
				u_depth_q <= ev_depth[trpa_pkg::U_CNT_W-1:0];
				u_wm_q    <= ev_wm[trpa_pkg::U_CNT_W-1:0];
			end
		end
	end

	// Freed-page stacks: push writes at the depth, pop reads just below it.
	assign k_we  = cmd.commit && ev_push && req_kern_q;
	assign k_re  = cmd.commit && ev_pop && req_kern_q;
	assign u_we  = cmd.commit && ev_push && !req_kern_q;
	assign u_re  = cmd.commit && ev_pop && !req_kern_q;
	assign k_top = k_depth_q - 1'b1;
	assign u_top = u_depth_q - 1'b1;

	trpa_ram #(
		.WIDTH(trpa_pkg::K_OFF_W),
		.DEPTH(trpa_pkg::KERNEL_PAGES_MAX)
	) u_kernel_stack (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_depth_q[trpa_pkg::K_OFF_W-1:0]),
		.wdata (diff[trpa_pkg::K_OFF_W-1:0]),
		.re    (k_re),
		.raddr (k_top[trpa_pkg::K_OFF_W-1:0]),
		.rdata (k_rdata)
	);

	trpa_ram #(
		.WIDTH(trpa_pkg::U_OFF_W),
		.DEPTH(trpa_pkg::USER_PAGES_MAX)
	) u_user_stack (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_depth_q[trpa_pkg::U_OFF_W-1:0]),
		.wdata (diff[trpa_pkg::U_OFF_W-1:0]),
		.re    (u_re),
		.raddr (u_top[trpa_pkg::U_OFF_W-1:0]),
		.rdata (u_rdata)
	);

	// Page popped from the stack, offset from the region start.
	assign pop_off  = req_kern_q ? trpa_pkg::PAGE_W'(k_rdata) : trpa_pkg::PAGE_W'(u_rdata);
	assign pop_page = req_start_q[trpa_pkg::PAGE_W-1:0] + pop_off;

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out_eval) begin
			out_q.page_address <= ev_page;
			out_q.status       <= ev_status;
			out_q.free_count   <= free_pages(ev_depth, ev_wm, sel_cnt);
		end else if (cmd.load_out_read) begin
			out_q.page_address <= {pop_page, {trpa_pkg::PAGE_SHIFT{1'b0}}};
			out_q.status       <= trpa_pkg::STAT_OK;
			out_q.free_count   <= free_pages(sel_depth, sel_wm, sel_cnt);
		end
	end

	assign out_item = out_q;

	`ASSERT_ALWAYS(a_k_depth_max, clk, arst_n, k_depth_q <= trpa_pkg::K_CNT_W'(trpa_pkg::KERNEL_PAGES_MAX))
	`ASSERT_ALWAYS(a_u_depth_max, clk, arst_n, u_depth_q <= trpa_pkg::U_CNT_W'(trpa_pkg::USER_PAGES_MAX))
	`ASSERT_IMP(a_pop_then_read, clk, arst_n, cmd.load_out_read, $past(k_re) || $past(u_re) || $past(cmd.load_out_read) == 1'b0)

endmodule

// File: rtl/two_region_page_allocator.sv
// Two-region page allocator: kernel and user regions, each with a LIFO stack of freed pages.
// A result is written to the output register once its request is evaluated; an allocation from
// a freed stack also passes through the stack memory, which has a registered read port.
// The controller runs one item at a time and takes no new item until the last is finished; a
// finished result waits in the output register while the next item is taken.
// Reset (arst_n low) clears depths and watermarks and restores the configuration registers.

module two_region_page_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [trpa_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [trpa_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  trpa_pkg::req_t                  in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output trpa_pkg::rsp_t                  out_item
);

	trpa_pkg::ctrl_cmd_t cmd;
	trpa_pkg::dp_stat_t  dp_stat;

	// Sequencing and handshakes.
	trpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	// Registers, region arithmetic and the two stacks.
	trpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.dp_stat   (dp_stat),
		.out_item  (out_item)
	);

endmodule

// File: tb/two_region_page_allocator_tb.sv
module two_region_page_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The package names three request codes; the fourth is reserved and must do nothing.
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [trpa_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [trpa_pkg::CFG_W-1:0]     cfg_wdata;
	logic                           in_valid;
	logic                           in_ready;
	trpa_pkg::req_t                 in_item;
	logic                           out_valid;
	logic                           out_ready;
	trpa_pkg::rsp_t                 out_item;

	two_region_page_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// Mirror of the allocator: configuration, freed-page stacks, depths and watermarks.
	logic [trpa_pkg::BASE_W-1:0]  region_base;
	logic [trpa_pkg::KCFG_W-1:0]  kernel_count;
	logic [trpa_pkg::UCFG_W-1:0]  user_count;
	logic [trpa_pkg::K_OFF_W-1:0] kernel_stack [trpa_pkg::KERNEL_PAGES_MAX];
	logic [trpa_pkg::U_OFF_W-1:0] user_stack [trpa_pkg::USER_PAGES_MAX];
	logic [trpa_pkg::K_CNT_W-1:0] kernel_depth;
	logic [trpa_pkg::U_CNT_W-1:0] user_depth;
	logic [trpa_pkg::K_CNT_W-1:0] kernel_mark;
	logic [trpa_pkg::U_CNT_W-1:0] user_mark;

	trpa_pkg::rsp_t              pending_rsp [$];
	logic [trpa_pkg::ADDR_W-1:0] kernel_held [$];
	logic [trpa_pkg::ADDR_W-1:0] user_held [$];
	int                          idle_pct;
	int                          ready_hold;
	int                          ready_gap;
	int                          mismatches;
	int                          stall_cycles;

	// Region size after clamping the programmed count to the stack capacity.
	function automatic logic [63:0] region_pages(input logic kern);
		logic [63:0] cnt;
		logic [63:0] cap;
		cnt = kern ? 64'(kernel_count) : 64'(user_count);
		cap = kern ? 64'(trpa_pkg::KERNEL_PAGES_MAX) : 64'(trpa_pkg::USER_PAGES_MAX);
		return (cnt > cap) ? cap : cnt;
	endfunction

	function automatic logic [63:0] region_first_page(input logic kern);
		return kern ? 64'(region_base) : 64'(region_base) + region_pages(1'b1);
	endfunction

	function automatic logic [trpa_pkg::ADDR_W-1:0] page_byte(input logic [63:0] pg);
		return trpa_pkg::ADDR_W'(pg << trpa_pkg::PAGE_SHIFT);
	endfunction

	// Stacked pages plus the never-issued pages left above the watermark.
	function automatic logic [trpa_pkg::CNT_W-1:0] pages_available(input logic kern);
		logic [63:0] cnt;
		logic [63:0] mark;
		logic [63:0] depth;
		logic [63:0] rest;
		cnt = region_pages(kern);
		mark = kern ? 64'(kernel_mark) : 64'(user_mark);
		depth = kern ? 64'(kernel_depth) : 64'(user_depth);
		rest = (cnt > mark) ? cnt - mark : 64'd0;
		return trpa_pkg::CNT_W'(depth + rest);
	endfunction

	// Applies one request to the mirror and returns the response it must produce.
	function automatic trpa_pkg::rsp_t allocator_response(input trpa_pkg::req_t r);
		logic           kern;
		logic [63:0]    depth;
		logic [63:0]    mark;
		logic [63:0]    cap;
		logic [63:0]    start;
		logic [63:0]    off;
		logic [63:0]    pg;
		trpa_pkg::rsp_t res;
		kern = r.kernel_sel;
		depth = kern ? 64'(kernel_depth) : 64'(user_depth);
		mark = kern ? 64'(kernel_mark) : 64'(user_mark);
		cap = kern ? 64'(trpa_pkg::KERNEL_PAGES_MAX) : 64'(trpa_pkg::USER_PAGES_MAX);
		start = region_first_page(kern);
		res = '0;
		res.status = trpa_pkg::STAT_OK;
		case (r.func)
		trpa_pkg::FN_ALLOC: begin
			if (depth > 0 && depth <= cap) begin
				depth = depth - 1;
				if (kern) begin
					off = 64'(kernel_stack[depth]);
				end else begin
					off = 64'(user_stack[depth]);
				end
				res.page_address = page_byte(start + off);
			end else if (mark < region_pages(kern)) begin
				res.page_address = page_byte(start + mark);
				mark = mark + 1;
			end else begin
				res.status = trpa_pkg::STAT_OOM;
			end
		end
		trpa_pkg::FN_FREE: begin
			pg = 64'(r.free_address >> trpa_pkg::PAGE_SHIFT);
			if (r.free_address[trpa_pkg::PAGE_SHIFT-1:0] != '0) begin
				res.status = trpa_pkg::STAT_UNALIGNED;
			end else if (pg < start || pg - start >= region_pages(kern)) begin
				res.status = trpa_pkg::STAT_RANGE;
			end else if (depth >= mark || depth >= cap) begin
				res.status = trpa_pkg::STAT_FULL;
			end else begin
				if (kern) begin
					kernel_stack[depth] = trpa_pkg::K_OFF_W'(pg - start);
				end else begin
					user_stack[depth] = trpa_pkg::U_OFF_W'(pg - start);
				end
				depth = depth + 1;
			end
		end
		default: ;
		endcase
		// Reinitialize empties both regions; every other request updates only its own.
		if (r.func == trpa_pkg::FN_INIT) begin
			kernel_depth = '0;
			user_depth = '0;
			kernel_mark = '0;
			user_mark = '0;
		end else if (kern) begin
			kernel_depth = trpa_pkg::K_CNT_W'(depth);
			kernel_mark = trpa_pkg::K_CNT_W'(mark);
		end else begin
			user_depth = trpa_pkg::U_CNT_W'(depth);
			user_mark = trpa_pkg::U_CNT_W'(mark);
		end
		res.free_count = pages_available(kern);
		return res;
	endfunction

	function automatic trpa_pkg::req_t make_req(input logic [1:0] func, input logic kern,
			input logic [trpa_pkg::ADDR_W-1:0] addr);
		trpa_pkg::req_t r;
		r.func = func;
		r.kernel_sel = kern;
		r.free_address = addr;
		return r;
	endfunction

	function automatic logic [trpa_pkg::ADDR_W-1:0] random_addr();
		return trpa_pkg::ADDR_W'({$urandom(), $urandom()});
	endfunction

	// Hands back a page that is still out on loan, or the fallback if none is.
	function automatic logic [trpa_pkg::ADDR_W-1:0] take_held(input logic kern,
			input logic [trpa_pkg::ADDR_W-1:0] fallback);
		int                          idx;
		logic [trpa_pkg::ADDR_W-1:0] addr;
		addr = fallback;
		if (kern && kernel_held.size() != 0) begin
			idx = $urandom_range(kernel_held.size() - 1, 0);
			addr = kernel_held[idx];
			kernel_held.delete(idx);
		end else if (!kern && user_held.size() != 0) begin
			idx = $urandom_range(user_held.size() - 1, 0);
			addr = user_held[idx];
			user_held.delete(idx);
		end
		return addr;
	endfunction

	// Mostly reinitialize and give back real pages; the rest is malformed or stray traffic.
	function automatic trpa_pkg::req_t random_request();
		trpa_pkg::req_t r;
		logic           kern;
		int             pick;
		logic [63:0]    start;
		logic [63:0]    cnt;
		logic [63:0]    pg;
		kern = 1'($urandom_range(1, 0));
		pick = $urandom_range(99, 0);
		start = region_first_page(kern);
		cnt = region_pages(kern);
		pg = start + ((cnt == 0) ? 64'd0 : 64'($urandom_range(32'(cnt - 1), 0)));
		r = make_req(trpa_pkg::FN_ALLOC, kern, random_addr());
		if (pick >= 44 && pick < 80) begin
			r.func = trpa_pkg::FN_FREE;
			r.free_address = take_held(kern, page_byte(pg));
		end else if (pick < 82) begin
			r.func = trpa_pkg::FN_INIT;
		end else if (pick < 86) begin
			r.func = trpa_pkg::FN_FREE;
			r.free_address = page_byte(pg) | trpa_pkg::ADDR_W'($urandom_range(4095, 1));
		end else if (pick < 90) begin
			r.func = trpa_pkg::FN_FREE;
			if ($urandom_range(1, 0) == 1) begin
				pg = start - 1 - $urandom_range(3, 0);
			end else begin
				pg = start + cnt + $urandom_range(3, 0);
			end
			r.free_address = page_byte(pg);
		end else if (pick < 94) begin
			r.func = trpa_pkg::FN_FREE;
		end else if (pick < 97) begin
			r.func = FN_UNUSED;
		end else if (pick >= 80) begin
			// A page of the region that may already sit on the stack.
			r.func = trpa_pkg::FN_FREE;
			r.free_address = page_byte(pg);
		end
		return r;
	endfunction

	// Offers one item, waits for it to be taken and records the response it must cause.
	task automatic send_req(input trpa_pkg::req_t r);
		trpa_pkg::rsp_t res;
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(17, 1)) @(negedge clk);
		end
		in_item <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		res = allocator_response(r);
		pending_rsp.push_back(res);
		if (r.func == trpa_pkg::FN_ALLOC && res.status == trpa_pkg::STAT_OK) begin
			if (r.kernel_sel) begin
				kernel_held.push_back(res.page_address);
			end else begin
				user_held.push_back(res.page_address);
			end
		end else if (r.func == trpa_pkg::FN_INIT) begin
			kernel_held.delete();
			user_held.delete();
		end
	endtask

	// Stops offering items and waits until every response has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// Programs all three registers while the block is idle.
	task automatic set_regions(input logic [trpa_pkg::CFG_W-1:0] base,
			input logic [trpa_pkg::CFG_W-1:0] kcnt, input logic [trpa_pkg::CFG_W-1:0] ucnt);
		logic [trpa_pkg::CFG_IDX_W-1:0] idx [3];
		logic [trpa_pkg::CFG_W-1:0]     val [3];
		idx = '{trpa_pkg::CFG_BASE, trpa_pkg::CFG_KCOUNT, trpa_pkg::CFG_UCOUNT};
		val = '{base, kcnt, ucnt};
		drain();
		for (int i = 0; i < 3; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
			case (idx[i])
			trpa_pkg::CFG_BASE: region_base = trpa_pkg::BASE_W'(val[i]);
			trpa_pkg::CFG_KCOUNT: kernel_count = trpa_pkg::KCFG_W'(val[i]);
			trpa_pkg::CFG_UCOUNT: user_count = trpa_pkg::UCFG_W'(val[i]);
			default: ;
			endcase
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		kernel_held.delete();
		user_held.delete();
	endtask

	// Reset layout: first pages, double free, full stack, bad alignment and range, unused code.
	task automatic test_reset_layout();
		logic [63:0] kstart;
		logic [63:0] ustart;
		idle_pct = 35;
		kstart = region_first_page(1'b1);
		ustart = region_first_page(1'b0);
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b1, '1));
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b1, '0));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, page_byte(kstart)));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, page_byte(kstart)));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, page_byte(kstart + 1)));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, page_byte(kstart) | trpa_pkg::ADDR_W'(1)));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, '1));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b0, page_byte(ustart + 64'(user_count))));
		send_req(make_req(FN_UNUSED, 1'b1, '1));
		send_req(make_req(trpa_pkg::FN_INIT, 1'b0, random_addr()));
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b0, '0));
	endtask

	// Register extremes: top base with address wrap, clamped counts, masked write data.
	task automatic test_register_extremes();
		set_regions('1, '1, '1);
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b1, '0));
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b0, '0));
		// The user region starts past the top of the page space, so this page is out of range.
		send_req(make_req(trpa_pkg::FN_FREE, 1'b0, page_byte(64'd1030)));
		set_regions('0, 44'hABC_DEF0_0001, 44'hFFF_FFFF_0000);
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b1, '0));
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b1, '0));
		send_req(make_req(trpa_pkg::FN_ALLOC, 1'b0, '0));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, '0));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b0, page_byte(64'd1)));
	endtask

	// A shrunk kernel region still hands out stacked pages above its new size, then runs out.
	task automatic test_region_shrink();
		logic [63:0] kstart;
		set_regions(44'h100, 44'd4, 44'd8);
		send_req(make_req(trpa_pkg::FN_INIT, 1'b1, '0));
		repeat (3) send_req(make_req(trpa_pkg::FN_ALLOC, 1'b1, '0));
		kstart = region_first_page(1'b1);
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, page_byte(kstart + 2)));
		send_req(make_req(trpa_pkg::FN_FREE, 1'b1, page_byte(kstart + 1)));
		set_regions(44'h100, 44'd1, 44'd8);
		repeat (3) send_req(make_req(trpa_pkg::FN_ALLOC, 1'b1, '0));
	endtask

	// Random traffic over several region layouts, with stretches of idling and none.
	task automatic test_random_traffic();
		logic [trpa_pkg::CFG_W-1:0] bases [5];
		logic [trpa_pkg::CFG_W-1:0] kcnts [5];
		logic [trpa_pkg::CFG_W-1:0] ucnts [5];
		bases = '{trpa_pkg::CFG_W'({$urandom(), $urandom()}), 44'h80000, 44'hFFF_FFFF_FFFD,
			44'h0, 44'd524288};
		kcnts = '{44'd5, 44'd12, 44'd0, 44'd64, 44'd1024};
		ucnts = '{44'd7, 44'd3, 44'd20, 44'd0, 44'd32768};
		for (int ph = 0; ph < 5; ph++) begin
			set_regions(bases[ph], kcnts[ph], ucnts[ph]);
			send_req(make_req(trpa_pkg::FN_INIT, 1'b0, '0));
			for (int i = 0; i < 280; i++) begin
				if (i % 70 == 0) begin
					idle_pct = ($urandom_range(1, 0) == 1) ? 0 : 35;
				end
				send_req(random_request());
			end
		end
	endtask

	// The receiver stops for a long stretch while items keep coming, so the block backs up.
	task automatic test_output_stall();
		set_regions(trpa_pkg::CFG_W'({$urandom(), $urandom()}), 44'd16, 44'd16);
		idle_pct = 0;
		send_req(make_req(trpa_pkg::FN_INIT, 1'b1, '0));
		ready_hold = HOLD_CYCLES;
		repeat (60) send_req(random_request());
	endtask

	// Closing traffic at full rate on both sides.
	task automatic test_full_rate();
		idle_pct = 0;
		set_regions(trpa_pkg::CFG_W'({$urandom(), $urandom()}), 44'd24, 44'd40);
		send_req(make_req(trpa_pkg::FN_INIT, 1'b0, '0));
		repeat (250) send_req(random_request());
	endtask

	// Receiver: random bursts of back-pressure, plus the long hold when one is requested.
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold = ready_hold - 1;
		end else if (ready_gap > 0) begin
			out_ready <= 1'b0;
			ready_gap = ready_gap - 1;
		end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct / 3) begin
			out_ready <= 1'b0;
			ready_gap = $urandom_range(16, 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Each response taken is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		trpa_pkg::rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response with nothing outstanding: %h", out_item);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (out_item.page_address !== want.page_address) begin
					$error("page_address: expected %h, got %h", want.page_address,
						out_item.page_address);
					mismatches++;
				end
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_item.status);
					mismatches++;
				end
				if (out_item.free_count !== want.free_count) begin
					$error("free_count: expected %0d, got %0d", want.free_count,
						out_item.free_count);
					mismatches++;
				end
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles = stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("two_region_page_allocator_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = trpa_pkg::CFG_BASE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		idle_pct = 0;
		ready_hold = 0;
		ready_gap = 0;
		mismatches = 0;
		stall_cycles = 0;
		region_base = trpa_pkg::BASE_RST;
		kernel_count = trpa_pkg::KCOUNT_RST;
		user_count = trpa_pkg::UCOUNT_RST;
		kernel_depth = '0;
		user_depth = '0;
		kernel_mark = '0;
		user_mark = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_layout();
		test_register_extremes();
		test_region_shrink();
		test_random_traffic();
		test_output_stall();
		test_full_rate();

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("two_region_page_allocator_tb: clean");
		end else begin
			$display("two_region_page_allocator_tb: errors");
		end
		$finish;
	end

endmodule
